// ===== rtl/core/lru_page_replacement_top_assert.svh =====
// assertion macros for the lru page replacement top level
`ifndef LRU_PAGE_REPLACEMENT_TOP_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LRUPR_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lrupr assertion failed");

// next-cycle implication, checked outside reset
`define LRUPR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lrupr assertion failed");

`endif

// ===== rtl/core/lrupr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lrupr_pkg;

    localparam int FRAME_SLOTS = 16;
    localparam int SLOT_W      = $clog2(FRAME_SLOTS);
    localparam int PAGE_BITS   = 16;
    localparam int STAMP_W     = 32;
    localparam int CNT_W       = 32;
    localparam int CFG_W       = 5;
    localparam int ENTRY_W     = PAGE_BITS + STAMP_W;

    localparam logic [CFG_W-1:0] CFG_FRAMES_RESET = CFG_W'(4);
    localparam logic [CNT_W-1:0] CNT_MAX          = '1;

    typedef struct packed {
        logic                 found;
        logic [SLOT_W-1:0]    slot;
        logic                 ev_valid;
        logic [PAGE_BITS-1:0] ev_page;
    } t_scan_res;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        r = (v == CNT_MAX) ? v : v + CNT_W'(1);
        return r;
    endfunction

    // index of the last frame taking part, count clamped to 1..FRAME_SLOTS
    function automatic logic [SLOT_W-1:0] frames_last(input logic [CFG_W-1:0] f);
        logic [SLOT_W-1:0] r;
        if (f == '0) begin
            r = '0;
        end else if (32'(f) > FRAME_SLOTS) begin
            r = SLOT_W'(FRAME_SLOTS - 1);
        end else begin
            r = SLOT_W'(f - CFG_W'(1));
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lrupr_frame_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lrupr_frame_ram #(
    parameter int DATA_W = 48,
    parameter int ADDR_W = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/core/lrupr_scan.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lrupr_scan (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_init,
    input  logic                             i_consume,
    input  logic [lrupr_pkg::SLOT_W-1:0]     i_idx,
    input  logic                             i_valid,
    input  logic [lrupr_pkg::PAGE_BITS-1:0]  i_page,
    input  logic [lrupr_pkg::STAMP_W-1:0]    i_stamp,
    input  logic [lrupr_pkg::PAGE_BITS-1:0]  i_req_page,
    output lrupr_pkg::t_scan_res             o_res
);

    logic                            r_found;
    logic                            r_empty;
    logic [lrupr_pkg::SLOT_W-1:0]    r_hit_slot;
    logic [lrupr_pkg::SLOT_W-1:0]    r_vic_slot;
    logic [lrupr_pkg::STAMP_W-1:0]   r_min;
    logic                            r_vic_valid;
    logic [lrupr_pkg::PAGE_BITS-1:0] r_vic_page;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
            r_empty <= 1'b0;
        end else if (i_init) begin
            r_found <= 1'b0;
            r_empty <= 1'b0;
        end else if (i_consume) begin
            // lowest matching frame wins
            if (!r_found && i_valid && (i_page == i_req_page)) begin
                r_found    <= 1'b1;
                r_hit_slot <= i_idx;
            end
            if (i_idx == '0) begin
                r_vic_slot  <= '0;
                r_min       <= i_stamp;
                r_vic_valid <= i_valid;
                r_vic_page  <= i_page;
            end else if (!r_empty) begin
                // first empty frame above frame 0 ends the victim search
                if (!i_valid) begin
                    r_empty     <= 1'b1;
                    r_vic_slot  <= i_idx;
                    r_vic_valid <= 1'b0;
                end else if (i_stamp < r_min) begin
                    r_min       <= i_stamp;
                    r_vic_slot  <= i_idx;
                    r_vic_valid <= 1'b1;
                    r_vic_page  <= i_page;
                end
            end
        end
    end

    assign o_res.found    = r_found;
    assign o_res.slot     = r_found ? r_hit_slot : r_vic_slot;
    assign o_res.ev_valid = !r_found && r_vic_valid;
    assign o_res.ev_page  = (!r_found && r_vic_valid) ? r_vic_page : '0;

endmodule

`default_nettype wire

// ===== rtl/core/lru_page_replacement_top.sv =====
// lru page replacement: one page reference per start, one result strobe per reference
// steps: the scan reads frames 0..n-1, n = frames (1..16), then drain and write precede the result strobe
// a new start is taken only when idle: busy stays high through scan, drain and write; one frame memory read per frame
// reset: synchronous active low; frames empty, counters zero, frames_in_use back to 4
// the result strobe lasts one cycle and cannot be stalled by the receiver
`timescale 1ns / 1ps
`default_nettype none

`include "lru_page_replacement_top_assert.svh"

module lru_page_replacement_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [lrupr_pkg::PAGE_BITS-1:0]  i_page_number,
    input  logic                             i_restart,
    output logic                             o_result_valid,
    output logic                             o_hit,
    output logic [3:0]                       o_frame_index,
    output logic                             o_evicted_valid,
    output logic [15:0]                      o_evicted_page,
    output logic [31:0]                      o_hit_total,
    output logic [31:0]                      o_fault_total,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [lrupr_pkg::CFG_W-1:0]      i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_WRITE = 4'b1000
    } t_state;

    t_state                              r_state, n_state;
    logic [lrupr_pkg::CFG_W-1:0]         r_frames;
    logic [lrupr_pkg::FRAME_SLOTS-1:0]   r_valid;
    logic [lrupr_pkg::CNT_W-1:0]         r_ref, r_hits, r_faults;
    logic [lrupr_pkg::PAGE_BITS-1:0]     r_page;
    logic [lrupr_pkg::SLOT_W-1:0]        r_last;
    logic [lrupr_pkg::SLOT_W-1:0]        r_idx;
    logic [lrupr_pkg::SLOT_W-1:0]        r_didx;
    logic                                r_dv;
    logic                                r_out_stb;
    logic                                r_hit_q;
    logic [lrupr_pkg::SLOT_W-1:0]        r_slot_q;
    logic                                r_ev_valid_q;
    logic [lrupr_pkg::PAGE_BITS-1:0]     r_ev_page_q;
    logic [lrupr_pkg::CNT_W-1:0]         r_hit_tot_q, r_fault_tot_q;

    logic                                accept;
    logic                                cfg_wr;
    logic                                mem_re, mem_we;
    logic [lrupr_pkg::ENTRY_W-1:0]       mem_rdata;
    logic [lrupr_pkg::ENTRY_W-1:0]       mem_wdata;
    logic                                ent_valid;
    logic [lrupr_pkg::PAGE_BITS-1:0]     ent_page;
    logic [lrupr_pkg::STAMP_W-1:0]       ent_stamp;
    lrupr_pkg::t_scan_res                scan_res;

    assign busy        = (r_state != S_IDLE);
    assign accept      = start && !busy;
    assign o_cfg_ready = !busy;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    assign mem_re    = (r_state == S_SCAN);
    assign mem_we    = (r_state == S_WRITE);
    assign mem_wdata = {r_page, r_ref};

    lrupr_frame_ram #(
        .DATA_W (lrupr_pkg::ENTRY_W),
        .ADDR_W (lrupr_pkg::SLOT_W)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (scan_res.slot),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (r_idx),
        .o_rdata (mem_rdata)
    );

    // an empty frame reads as stamp zero
    assign ent_valid = r_valid[r_didx];
    assign ent_page  = mem_rdata[lrupr_pkg::ENTRY_W-1:lrupr_pkg::STAMP_W];
    assign ent_stamp = ent_valid ? mem_rdata[lrupr_pkg::STAMP_W-1:0] : '0;

    lrupr_scan u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_init     (accept),
        .i_consume  (r_dv),
        .i_idx      (r_didx),
        .i_valid    (ent_valid),
        .i_page     (ent_page),
        .i_stamp    (ent_stamp),
        .i_req_page (r_page),
        .o_res      (scan_res)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_idx == r_last) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                n_state = S_WRITE;
            end
            S_WRITE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_frames  <= lrupr_pkg::CFG_FRAMES_RESET;
            r_valid   <= '0;
            r_ref     <= '0;
            r_hits    <= '0;
            r_faults  <= '0;
            r_dv      <= 1'b0;
            r_out_stb <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_dv      <= (r_state == S_SCAN);
            r_out_stb <= (r_state == S_WRITE);
            if (cfg_wr) begin
                r_frames <= i_cfg_data;
            end
            if (accept && i_restart) begin
                r_valid  <= '0;
                r_ref    <= '0;
                r_hits   <= '0;
                r_faults <= '0;
            end
            if (r_state == S_WRITE) begin
                r_valid[scan_res.slot] <= 1'b1;
                r_ref                  <= lrupr_pkg::sat_inc(r_ref);
                if (scan_res.found) begin
                    r_hits <= lrupr_pkg::sat_inc(r_hits);
                end else begin
                    r_faults <= lrupr_pkg::sat_inc(r_faults);
                end
            end
        end
    end

    // transaction payload and scan addressing
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_page <= i_page_number;
            r_last <= lrupr_pkg::frames_last(r_frames);
            r_idx  <= '0;
        end else if (r_state == S_SCAN) begin
            r_idx <= r_idx + lrupr_pkg::SLOT_W'(1);
        end
        r_didx <= r_idx;
        if (r_state == S_WRITE) begin
            r_hit_q      <= scan_res.found;
            r_slot_q     <= scan_res.slot;
            r_ev_valid_q <= scan_res.ev_valid;
            r_ev_page_q  <= scan_res.ev_page;
            r_hit_tot_q  <= scan_res.found ? lrupr_pkg::sat_inc(r_hits) : r_hits;
            r_fault_tot_q <= scan_res.found ? r_faults : lrupr_pkg::sat_inc(r_faults);
        end
    end

    assign o_result_valid  = r_out_stb;
    assign o_hit           = r_hit_q;
    assign o_frame_index   = 4'(r_slot_q);
    assign o_evicted_valid = r_ev_valid_q;
    assign o_evicted_page  = 16'(r_ev_page_q);
    assign o_hit_total     = 32'(r_hit_tot_q);
    assign o_fault_total   = 32'(r_fault_tot_q);

    `LRUPR_ASSERT_NEXT(a_write_strobes, r_state == S_WRITE, o_result_valid)
    `LRUPR_ASSERT_SAME(a_evict_on_fault, o_result_valid && o_evicted_valid, !o_hit)
    `LRUPR_ASSERT_SAME(a_frame_in_range, o_result_valid, r_slot_q <= r_last)
    `LRUPR_ASSERT_SAME(a_frame_marked, o_result_valid, r_valid[r_slot_q])

endmodule

`default_nettype wire

// ===== test/lru_page_replacement_top_tb.sv =====
`timescale 1ns / 1ps

module lru_page_replacement_top_tb;

    localparam int FRAME_SLOTS = lrupr_pkg::FRAME_SLOTS;
    localparam int PAGE_BITS   = lrupr_pkg::PAGE_BITS;
    localparam int STAMP_W     = lrupr_pkg::STAMP_W;
    localparam int CNT_W       = lrupr_pkg::CNT_W;
    localparam int CFG_W       = lrupr_pkg::CFG_W;
    localparam logic [CFG_W-1:0] CFG_FRAMES_RESET = lrupr_pkg::CFG_FRAMES_RESET;

    localparam int TIMEOUT_CYCLES = 1_000_000;
    localparam int RANDOM_PHASES  = 12;
    localparam int REFS_PER_PHASE = 160;
    localparam int DRAIN_CYCLES   = 40;

    // frame counts for the first random phases, entry 0 in the low bits
    localparam logic [8*CFG_W-1:0] FRAME_PLAN = {
        5'd4, 5'd15, 5'd2, 5'd17, 5'd31, 5'd0, 5'd1, 5'd16
    };

    typedef enum logic {OP_REFERENCE, OP_SET_FRAMES} t_op_kind;

    typedef struct packed {
        t_op_kind             kind;
        logic [PAGE_BITS-1:0] page;
        logic                 restart;
        logic [CFG_W-1:0]     frames;
        logic [3:0]           gap;
    } t_page_op;

    typedef struct packed {
        logic             hit;
        logic [3:0]       frame_index;
        logic             evicted_valid;
        logic [15:0]      evicted_page;
        logic [CNT_W-1:0] hit_total;
        logic [CNT_W-1:0] fault_total;
    } t_ref_outcome;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 start          = 1'b0;
    logic [PAGE_BITS-1:0] i_page_number  = '0;
    logic                 i_restart      = 1'b0;
    logic                 i_cfg_valid    = 1'b0;
    logic [CFG_W-1:0]     i_cfg_data     = '0;
    logic                 busy;
    logic                 o_result_valid;
    logic                 o_hit;
    logic [3:0]           o_frame_index;
    logic                 o_evicted_valid;
    logic [15:0]          o_evicted_page;
    logic [31:0]          o_hit_total;
    logic [31:0]          o_fault_total;
    logic                 o_cfg_ready;

    t_page_op     page_ops_q[$];
    t_ref_outcome expected_outcomes_q[$];

    // predictor state
    logic [PAGE_BITS-1:0] mdl_page  [FRAME_SLOTS];
    bit                   mdl_valid [FRAME_SLOTS];
    bit [STAMP_W-1:0]     mdl_stamp [FRAME_SLOTS];
    bit [CNT_W-1:0]       mdl_refs;
    bit [CNT_W-1:0]       mdl_hits;
    bit [CNT_W-1:0]       mdl_faults;
    logic [CFG_W-1:0]     mdl_frames = CFG_FRAMES_RESET;

    logic [3:0] gap_left       = '0;
    int         refs_in_flight = 0;
    logic       stim_drained   = 1'b0;
    int         fail_count     = 0;
    int         cycle_count    = 0;

    lru_page_replacement_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_page_number   (i_page_number),
        .i_restart       (i_restart),
        .o_result_valid  (o_result_valid),
        .o_hit           (o_hit),
        .o_frame_index   (o_frame_index),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_page  (o_evicted_page),
        .o_hit_total     (o_hit_total),
        .o_fault_total   (o_fault_total),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int active_frames(input logic [CFG_W-1:0] cfg);
        int n;
        n = int'(cfg);
        if (n < 1) n = 1;
        if (n > FRAME_SLOTS) n = FRAME_SLOTS;
        return n;
    endfunction

    function automatic logic [3:0] draw_gap(input int style);
        logic [3:0] g;
        case (style)
            0: g = '0;
            1: g = 4'($urandom_range(0, 15));
            default: g = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(1, 15)) : 4'd0;
        endcase
        return g;
    endfunction

    task automatic clear_frames();
        for (int j = 0; j < FRAME_SLOTS; j++) begin
            mdl_page[j]  = '0;
            mdl_valid[j] = 1'b0;
            mdl_stamp[j] = '0;
        end
        mdl_refs   = '0;
        mdl_hits   = '0;
        mdl_faults = '0;
    endtask

    task automatic lru_reference(input logic [PAGE_BITS-1:0] page, input logic restart,
                                 output t_ref_outcome res);
        int               n;
        int               slot;
        bit               found;
        bit               picked;
        bit [STAMP_W-1:0] now;
        if (restart) clear_frames();
        n      = active_frames(mdl_frames);
        now    = mdl_refs;
        found  = 1'b0;
        picked = 1'b0;
        slot   = 0;
        res.evicted_valid = 1'b0;
        res.evicted_page  = '0;
        // lowest matching frame wins, frames past the count are ignored
        for (int j = 0; j < n; j++) begin
            if (!found && mdl_valid[j] && mdl_page[j] == page) begin
                found = 1'b1;
                slot  = j;
            end
        end
        if (found) begin
            mdl_stamp[slot] = now;
            if (mdl_hits != '1) mdl_hits++;
        end else begin
            // first empty frame from 1 up, else strictly oldest stamp from frame 0
            for (int j = 1; j < n && !picked; j++) begin
                if (!mdl_valid[j]) begin
                    slot   = j;
                    picked = 1'b1;
                end else if (mdl_stamp[j] < mdl_stamp[slot]) begin
                    slot = j;
                end
            end
            if (mdl_valid[slot]) begin
                res.evicted_valid = 1'b1;
                res.evicted_page  = mdl_page[slot];
            end
            mdl_page[slot]  = page;
            mdl_valid[slot] = 1'b1;
            mdl_stamp[slot] = now;
            if (mdl_faults != '1) mdl_faults++;
        end
        if (mdl_refs != '1) mdl_refs++;
        res.hit         = found;
        res.frame_index = 4'(slot);
        res.hit_total   = mdl_hits;
        res.fault_total = mdl_faults;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    task automatic add_ref(input logic [PAGE_BITS-1:0] page, input logic restart,
                           input logic [3:0] gap);
        t_page_op op;
        op.kind    = OP_REFERENCE;
        op.page    = page;
        op.restart = restart;
        op.frames  = '0;
        op.gap     = gap;
        page_ops_q.push_back(op);
    endtask

    task automatic add_set_frames(input logic [CFG_W-1:0] frames);
        t_page_op op;
        op.kind    = OP_SET_FRAMES;
        op.page    = '0;
        op.restart = 1'b0;
        op.frames  = frames;
        op.gap     = '0;
        page_ops_q.push_back(op);
    endtask

    // driver: references go out back to back or after a gap, frame count writes only when idle
    always @(posedge i_clk) begin
        t_page_op   op;
        logic       hold;
        logic       nxt_start;
        logic       nxt_cfg_valid;
        logic [3:0] gap_nxt;
        int         in_flight;
        if (!i_rst_n) begin
            start          <= 1'b0;
            i_cfg_valid    <= 1'b0;
            gap_left       <= '0;
            refs_in_flight <= 0;
            stim_drained   <= 1'b0;
        end else begin
            in_flight     = refs_in_flight + int'(start && !busy) - int'(o_result_valid);
            hold          = (start && busy) || (i_cfg_valid && !o_cfg_ready);
            nxt_start     = hold && start;
            nxt_cfg_valid = hold && i_cfg_valid;
            gap_nxt       = gap_left;
            if (!hold) begin
                if (gap_left != '0) begin
                    gap_nxt = gap_left - 4'd1;
                end else if (page_ops_q.size() != 0) begin
                    if (page_ops_q[0].kind == OP_REFERENCE) begin
                        op            = page_ops_q.pop_front();
                        nxt_start     = 1'b1;
                        i_page_number <= op.page;
                        i_restart     <= op.restart;
                        gap_nxt       = op.gap;
                    end else if (in_flight == 0 && !busy) begin
                        op            = page_ops_q.pop_front();
                        nxt_cfg_valid = 1'b1;
                        i_cfg_data    <= op.frames;
                        gap_nxt       = op.gap;
                    end
                end
            end
            start          <= nxt_start;
            i_cfg_valid    <= nxt_cfg_valid;
            gap_left       <= gap_nxt;
            refs_in_flight <= in_flight;
            stim_drained   <= (page_ops_q.size() == 0) && !nxt_start && !nxt_cfg_valid
                              && (in_flight == 0);
        end
    end

    // monitor: predicts on each accepted reference, checks each result strobe
    always @(posedge i_clk) begin
        t_ref_outcome want;
        if (!i_rst_n) begin
            clear_frames();
            mdl_frames = CFG_FRAMES_RESET;
            expected_outcomes_q.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) mdl_frames = i_cfg_data;
            if (start && !busy) begin
                lru_reference(i_page_number, i_restart, want);
                expected_outcomes_q.push_back(want);
            end
            if (o_result_valid) begin
                if (expected_outcomes_q.size() == 0) begin
                    $error("result transaction with no reference pending");
                    fail_count++;
                end else begin
                    want = expected_outcomes_q.pop_front();
                    check_field("hit", 32'(want.hit), 32'(o_hit));
                    check_field("frame_index", 32'(want.frame_index), 32'(o_frame_index));
                    check_field("evicted_valid", 32'(want.evicted_valid),
                                32'(o_evicted_valid));
                    check_field("evicted_page", 32'(want.evicted_page), 32'(o_evicted_page));
                    check_field("hit_total", want.hit_total, o_hit_total);
                    check_field("fault_total", want.fault_total, o_fault_total);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == TIMEOUT_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        logic [PAGE_BITS-1:0] working_set [20];
        logic [PAGE_BITS-1:0] page;
        logic [CFG_W-1:0]     frames;
        logic                 restart;
        logic                 first_restart;
        logic                 narrow;
        int                   ws_size;
        int                   gap_style;
        int                   pick;

        // directed: fill, hit, evict and restart with four frames
        add_ref(16'h0000, 1'b0, draw_gap(1));
        add_ref(16'hFFFF, 1'b0, draw_gap(0));
        add_ref(16'h0000, 1'b0, draw_gap(1));
        add_ref(16'h8001, 1'b0, draw_gap(0));
        add_ref(16'h7FFE, 1'b0, draw_gap(1));
        add_ref(16'hFFFF, 1'b0, draw_gap(0));
        add_ref(16'h1234, 1'b0, draw_gap(1));
        add_ref(16'h1234, 1'b1, draw_gap(0));
        add_ref(16'h1234, 1'b0, draw_gap(1));
        add_ref(16'h00FF, 1'b0, draw_gap(0));
        add_ref(16'hFF00, 1'b0, draw_gap(1));
        add_ref(16'h5A5A, 1'b0, draw_gap(0));
        add_ref(16'hA5A5, 1'b0, draw_gap(1));
        // shrink without restart, upper frames keep their pages
        add_set_frames(5'd1);
        add_ref(16'h00FF, 1'b0, draw_gap(0));
        add_ref(16'h3C3C, 1'b0, draw_gap(1));
        add_ref(16'h3C3C, 1'b0, draw_gap(0));
        // grow again so the hidden pages can hit
        add_set_frames(5'd16);
        add_ref(16'hFF00, 1'b0, draw_gap(1));
        add_ref(16'h5A5A, 1'b0, draw_gap(0));
        add_ref(16'hA5A5, 1'b0, draw_gap(1));
        add_ref(16'h1234, 1'b0, draw_gap(0));
        // out of range counts clamp to one and to all frames
        add_set_frames(5'd0);
        add_ref(16'h0001, 1'b0, draw_gap(1));
        add_ref(16'h0001, 1'b0, draw_gap(0));
        add_set_frames(5'd31);
        add_ref(16'h0002, 1'b0, draw_gap(1));
        add_ref(16'h0003, 1'b0, draw_gap(0));

        // random phases: working sets near the frame count so lru order matters
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            frames = (p < 8) ? FRAME_PLAN[p*CFG_W +: CFG_W] : CFG_W'($urandom_range(0, 31));
            add_set_frames(frames);
            ws_size       = $urandom_range(1, active_frames(frames) + 3);
            narrow        = ($urandom_range(0, 3) == 0);
            first_restart = 1'($urandom_range(0, 1));
            gap_style     = $urandom_range(0, 2);
            for (int k = 0; k < ws_size; k++) begin
                working_set[k] = narrow ? PAGE_BITS'($urandom_range(0, 31))
                                        : PAGE_BITS'($urandom_range(0, 65535));
            end
            for (int k = 0; k < REFS_PER_PHASE; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 80) begin
                    page = working_set[$urandom_range(0, ws_size - 1)];
                end else if (pick < 94) begin
                    page = PAGE_BITS'($urandom_range(0, 65535));
                end else begin
                    page = (pick < 97) ? '0 : '1;
                end
                restart = (k == 0 && first_restart) || ($urandom_range(0, 59) == 0);
                add_ref(page, restart, draw_gap(gap_style));
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(posedge i_clk); while (!stim_drained);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_outcomes_q.size() != 0) begin
            $error("%0d result transactions never arrived", expected_outcomes_q.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
